@@ src/dns_query_to_fixed_answer_defines.svh @@
// Assertion macros for the DNS fixed-answer responder.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef DNS_QUERY_TO_FIXED_ANSWER_DEFINES_SVH
`define DNS_QUERY_TO_FIXED_ANSWER_DEFINES_SVH

// same-cycle implication
`define DQFA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DQFA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/dqfa_pkg.sv @@
// Shared types, constants and the answer-record table for the DNS responder.
// No dependencies.
`default_nettype none

package dqfa_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 512;
  localparam int unsigned MAX_ANSWERS     = 3;
  localparam int unsigned QDEPTH          = 4;
  localparam int unsigned QPTR_W          = $clog2(QDEPTH);
  localparam int unsigned QCNT_W          = $clog2(QDEPTH + 1);

  // frame status codes
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_OVERSIZE     = 3'd1;
  localparam logic [2:0] ST_NO_QUESTIONS = 3'd2;
  localparam logic [2:0] ST_MALFORMED    = 3'd3;
  localparam logic [2:0] ST_TOO_MANY     = 3'd4;

  // parser phases
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_LENGTH = 2'd1;
  localparam logic [1:0] PH_SKIP   = 2'd2;
  localparam logic [1:0] PH_TRAIL  = 2'd3;

  // register byte address index
  localparam logic REG_TARGET_IP = 1'b0;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] resp_byte;
    logic       resp_last;
    logic [2:0] frame_status;
  } out_item_t;

  // work handed from the parser to the emitter
  typedef struct packed {
    logic       echo_en;
    logic [7:0] echo_byte;
    logic       fin;
    logic [2:0] status;
    logic [1:0] ans_cnt;
  } cmd_t;

  // one byte of the 16-byte A record
  function automatic logic [7:0] ans_byte(input logic [3:0] idx, input logic [31:0] ip);
    logic [7:0] v;
    unique case (idx)
      4'd0:    v = 8'hC0;
      4'd1:    v = 8'h0C;
      4'd3:    v = 8'h01;
      4'd5:    v = 8'h01;
      4'd9:    v = 8'h1E;
      4'd11:   v = 8'h04;
      4'd12:   v = ip[31:24];
      4'd13:   v = ip[23:16];
      4'd14:   v = ip[15:8];
      4'd15:   v = ip[7:0];
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ src/dns_query_to_fixed_answer.sv @@
// A pushed query byte passes through the command queue and then the output register.
// Throughput: one query byte per cycle; a frame end with answers holds the emitter
// for one 16-byte record per answer (plus the echo byte), the 4-entry command queue
// absorbing the following bytes until it fills and input stalls.
// Reset: asynchronous, active low; clears parser, queue and output valid; target_ip
// returns to 0.
`default_nettype none
`include "dns_query_to_fixed_answer_defines.svh"

module dns_query_to_fixed_answer import dqfa_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_item_t    in_item_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_item_t        out_item_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [31:0] target_ip_q;
  logic        accept, push, pop, empty, full;
  cmd_t        cmd, head;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TARGET_IP) ? target_ip_q : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_ip_q <= '0;
    end else if (psel && penable && pwrite && paddr[2] == REG_TARGET_IP) begin
      target_ip_q <= pwdata;
    end
  end

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  dqfa_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_item_i),
    .push_o   (push),
    .cmd_o    (cmd)
  );

  dqfa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty),
    .full_o  (full)
  );

  dqfa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .target_ip_i (target_ip_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  `DQFA_ASSERT_IMP(a_status_on_last, out_valid_o && out_item_o.frame_status != ST_OK,
    out_item_o.resp_last, "nonzero status on a non-final item")
  `DQFA_ASSERT_IMP(a_drop_byte_zero, out_valid_o && out_item_o.frame_status != ST_OK,
    out_item_o.resp_byte == 8'h00, "dropped frame item carries data")
  `DQFA_ASSERT_NXT(a_pop_frees_slot, pop && !push && full, !in_stall_o,
    "queue stays full after a pop")

endmodule

`default_nettype wire

@@ src/dqfa_front.sv @@
// Query parser: walks header and questions, classifies each byte into a command.
// Depends on dqfa_pkg.
`default_nettype none

module dqfa_front import dqfa_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     accept_i,
  input  wire in_item_t item_i,
  output logic          push_o,
  output cmd_t          cmd_o
);

  logic [9:0]  bpos_q, bpos_d;
  logic [15:0] qt_q, qt_d;
  logic [15:0] qd_q, qd_d;
  logic [1:0]  phase_q, phase_d;
  logic [7:0]  skip_q, skip_d;
  logic        ovs_q, ovs_d;

  logic [7:0]  b, ob, skip_dec;
  logic        echo;
  logic [2:0]  cause;

  always_comb begin
    b        = item_i.data_byte;
    ob       = b;
    echo     = 1'b0;
    ovs_d    = ovs_q | (bpos_q >= 10'(MAX_FRAME_BYTES));
    bpos_d   = (bpos_q != 10'h3FF) ? bpos_q + 10'd1 : bpos_q;
    qt_d     = qt_q;
    qd_d     = qd_q;
    phase_d  = phase_q;
    skip_d   = skip_q;
    skip_dec = (skip_q != 8'd0) ? skip_q - 8'd1 : skip_q;

    unique case (phase_q)
      PH_HEADER: begin
        echo = 1'b1;
        unique if (bpos_q == 10'd2) ob = 8'h81;
        else if (bpos_q == 10'd3) ob = 8'h80;
        else if (bpos_q == 10'd4) qt_d = {b, qt_q[7:0]};
        else if (bpos_q == 10'd5) qt_d = {qt_q[15:8], b};
        else if (bpos_q == 10'd6) ob = qt_q[15:8];
        else if (bpos_q == 10'd7) ob = qt_q[7:0];
        else if (bpos_q >= 10'd8) ob = 8'h00;
        else ob = b;
        if (bpos_q >= 10'd11) begin
          phase_d = (qt_d != 16'd0) ? PH_LENGTH : PH_TRAIL;
        end
      end
      PH_LENGTH: begin
        echo = 1'b1;
        if (b == 8'd0) begin
          if (qd_q != 16'hFFFF) qd_d = qd_q + 16'd1;
          skip_d = 8'd4;
        end else begin
          skip_d = b;
        end
        phase_d = PH_SKIP;
      end
      PH_SKIP: begin
        echo   = 1'b1;
        skip_d = skip_dec;
        if (skip_dec == 8'd0) begin
          phase_d = (qd_q >= qt_q) ? PH_TRAIL : PH_LENGTH;
        end
      end
      default: ;
    endcase

    // drop cause, by priority
    priority if (ovs_d) cause = ST_OVERSIZE;
    else if (phase_d == PH_HEADER) cause = ST_MALFORMED;
    else if (qt_d == 16'd0) cause = ST_NO_QUESTIONS;
    else if (qt_d > 16'(MAX_ANSWERS)) cause = ST_TOO_MANY;
    else if (phase_d != PH_TRAIL) cause = ST_MALFORMED;
    else cause = ST_OK;

    cmd_o.fin       = item_i.frame_end;
    cmd_o.echo_en   = echo && !(item_i.frame_end && cause != ST_OK);
    cmd_o.echo_byte = ob;
    cmd_o.status    = item_i.frame_end ? cause : ST_OK;
    cmd_o.ans_cnt   = qt_d[1:0];
    push_o          = accept_i && (echo || item_i.frame_end);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpos_q  <= '0;
      qt_q    <= '0;
      qd_q    <= '0;
      phase_q <= PH_HEADER;
      skip_q  <= '0;
      ovs_q   <= 1'b0;
    end else if (accept_i) begin
      if (item_i.frame_end) begin
        bpos_q  <= '0;
        qt_q    <= '0;
        qd_q    <= '0;
        phase_q <= PH_HEADER;
        skip_q  <= '0;
        ovs_q   <= 1'b0;
      end else begin
        bpos_q  <= bpos_d;
        qt_q    <= qt_d;
        qd_q    <= qd_d;
        phase_q <= phase_d;
        skip_q  <= skip_d;
        ovs_q   <= ovs_d;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/dqfa_queue.sv @@
// Small command queue between parser and emitter.
// Depends on dqfa_pkg.
`default_nettype none

module dqfa_queue import dqfa_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  input  wire logic pop_i,
  output cmd_t      head_o,
  output logic      empty_o,
  output logic      full_o
);

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + QPTR_W'(1);
      if (pop_i)  rd_q <= rd_q + QPTR_W'(1);
      cnt_q <= cnt_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
    end
  end

endmodule

`default_nettype wire

@@ src/dqfa_back.sv @@
// Emitter: turns queued commands into response items through an output register.
// Depends on dqfa_pkg.
`default_nettype none

module dqfa_back import dqfa_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cmd_t        head_i,
  input  wire logic        empty_i,
  output logic             pop_o,
  input  wire logic [31:0] target_ip_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_item_t        out_item_o
);

  logic       out_valid_q;
  out_item_t  out_q, out_d;
  logic       echo_done_q, echo_done_d;
  logic [1:0] ans_q, ans_d;
  logic [3:0] idx_q, idx_d;
  logic       load, rec_last;

  assign load     = (!out_valid_q || !out_stall_i) && !empty_i;
  assign rec_last = (2'(ans_q + 2'd1) == head_i.ans_cnt) && (idx_q == 4'd15);

  always_comb begin
    out_d       = out_q;
    pop_o       = 1'b0;
    echo_done_d = echo_done_q;
    ans_d       = ans_q;
    idx_d       = idx_q;
    if (load) begin
      priority if (head_i.echo_en && !echo_done_q) begin
        out_d = '{resp_byte: head_i.echo_byte, resp_last: 1'b0, frame_status: ST_OK};
        if (head_i.fin) echo_done_d = 1'b1;
        else pop_o = 1'b1;
      end else if (head_i.status != ST_OK) begin
        // dropped frame: a single status item
        out_d       = '{resp_byte: 8'h00, resp_last: 1'b1, frame_status: head_i.status};
        pop_o       = 1'b1;
        echo_done_d = 1'b0;
      end else begin
        out_d = '{resp_byte: ans_byte(idx_q, target_ip_i), resp_last: rec_last,
                  frame_status: ST_OK};
        idx_d = idx_q + 4'd1;
        if (idx_q == 4'd15) begin
          if (rec_last) begin
            pop_o       = 1'b1;
            ans_d       = 2'd0;
            echo_done_d = 1'b0;
          end else begin
            ans_d = ans_q + 2'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      echo_done_q <= 1'b0;
      ans_q       <= '0;
      idx_q       <= '0;
    end else begin
      if (!out_valid_q || !out_stall_i) out_valid_q <= !empty_i;
      echo_done_q <= echo_done_d;
      ans_q       <= ans_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire
